// ===== sv/grbw_pkg.sv =====
// Shared types, constants and control word layout for the grid ray block walker.
package grbw_pkg;

	localparam int COORD_W   = 32;
	localparam int BLK_IN_W  = 8;
	localparam int VISIT_W   = 8;
	localparam int FRAC_W    = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PART_W    = FRAC_W + 1;
	localparam int PROD_W    = PART_W + 1 + COORD_W;

	localparam int MAX_STEPS_DEF        = 64;
	localparam int BLOCK_SHIFT_DEF      = 7;
	localparam int BLOCK_COORD_BITS_DEF = 8;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [PART_W-1:0]         FRAC_ONE    = PART_W'(1) << FRAC_W;
	localparam logic signed [COORD_W-1:0] STILL_SLOPE = 32'sh0100_0000;
	localparam logic signed [COORD_W-1:0] SLOPE_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] SLOPE_MIN   = 32'sh8000_0000;

	localparam int PC_W = 4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SETUP,
		OP_SLOPE,
		OP_MUL,
		OP_ICPT,
		OP_EMIT
	} op_t;

	// AXIS_X: x is the stepping axis, giving the y slope and y intercept
	typedef enum logic {
		AXIS_X,
		AXIS_Y
	} axis_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_INPUT,
		HOLD_DIV,
		HOLD_EMIT
	} hold_t;

	typedef struct packed {
		op_t             op;
		axis_t           axis;
		hold_t           hold;
		logic [PC_W-1:0] next_pc;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic emit_last;
	} stat_t;

	typedef struct packed {
		logic              start;
		logic [DIFF_W-1:0] mag;
		logic [DIFF_W-1:0] den;
		logic              neg;
	} div_req_t;

	typedef struct packed {
		logic                        busy;
		logic signed [COORD_W-1:0]   slope;
	} div_rsp_t;

endpackage

// ===== sv/grbw_ifs.sv =====
// Ray input and block visit output channel interfaces.
interface grbw_ray_if import grbw_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  start_x;
	logic signed [COORD_W-1:0]  start_y;
	logic signed [COORD_W-1:0]  end_x;
	logic signed [COORD_W-1:0]  end_y;
	logic [BLK_IN_W-1:0]        start_block_x;
	logic [BLK_IN_W-1:0]        start_block_y;
	logic [BLK_IN_W-1:0]        end_block_x;
	logic [BLK_IN_W-1:0]        end_block_y;

	modport source (
		output valid, start_x, start_y, end_x, end_y,
		       start_block_x, start_block_y, end_block_x, end_block_y,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, end_x, end_y,
		       start_block_x, start_block_y, end_block_x, end_block_y,
		output ready
	);
endinterface

interface grbw_visit_if import grbw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VISIT_W-1:0] visit_x;
	logic [VISIT_W-1:0] visit_y;
	logic               last_visit;
	logic               reached_end;

	modport source (
		output valid, visit_x, visit_y, last_visit, reached_end,
		input  ready
	);
	modport sink (
		input  valid, visit_x, visit_y, last_visit, reached_end,
		output ready
	);
endinterface

// ===== sv/grbw_ucode.sv =====
// Microcode ROM and step counter with conditional hold and jump.
module grbw_ucode import grbw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [PC_W-1:0] pc_q;
	logic            hold;

	function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		cw = '{op: OP_NOP, axis: AXIS_X, hold: HOLD_NONE, next_pc: '0};
		case (pc)
			4'd0:  cw = '{op: OP_LOAD,  axis: AXIS_X, hold: HOLD_INPUT, next_pc: 4'd1};
			4'd1:  cw = '{op: OP_SETUP, axis: AXIS_X, hold: HOLD_NONE,  next_pc: 4'd2};
			4'd2:  cw = '{op: OP_NOP,   axis: AXIS_X, hold: HOLD_DIV,   next_pc: 4'd3};
			4'd3:  cw = '{op: OP_SLOPE, axis: AXIS_X, hold: HOLD_NONE,  next_pc: 4'd4};
			4'd4:  cw = '{op: OP_MUL,   axis: AXIS_X, hold: HOLD_NONE,  next_pc: 4'd5};
			4'd5:  cw = '{op: OP_ICPT,  axis: AXIS_X, hold: HOLD_NONE,  next_pc: 4'd6};
			4'd6:  cw = '{op: OP_SETUP, axis: AXIS_Y, hold: HOLD_NONE,  next_pc: 4'd7};
			4'd7:  cw = '{op: OP_NOP,   axis: AXIS_Y, hold: HOLD_DIV,   next_pc: 4'd8};
			4'd8:  cw = '{op: OP_SLOPE, axis: AXIS_Y, hold: HOLD_NONE,  next_pc: 4'd9};
			4'd9:  cw = '{op: OP_MUL,   axis: AXIS_Y, hold: HOLD_NONE,  next_pc: 4'd10};
			4'd10: cw = '{op: OP_ICPT,  axis: AXIS_Y, hold: HOLD_NONE,  next_pc: 4'd11};
			4'd11: cw = '{op: OP_EMIT,  axis: AXIS_X, hold: HOLD_EMIT,  next_pc: 4'd0};
			default: cw = '{op: OP_NOP, axis: AXIS_X, hold: HOLD_NONE,  next_pc: 4'd0};
		endcase
		return cw;
	endfunction

	assign ctrl = rom(pc_q);

	always_comb begin
		case (ctrl.hold)
			HOLD_INPUT: hold = !stat.in_valid;
			HOLD_DIV:   hold = stat.div_busy;
			HOLD_EMIT:  hold = !stat.emit_last;
			default:    hold = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (!hold) begin
			pc_q <= ctrl.next_pc;
		end
	end

endmodule

// ===== sv/grbw_div.sv =====
// Serial restoring divider for the 16.16 slope, with saturation to 32 bits.
module grbw_div import grbw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                   busy_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [DIFF_W-1:0]      rem_q;
	logic [DIFF_W-1:0]      den_q;
	logic [COORD_W-1:0]     num_q;
	logic [COORD_W-1:0]     quo_q;
	logic                   neg_q;
	logic                   zero_q;
	logic                   sat_q;

	logic [DIFF_W-1:0]      top;
	logic                   zero;
	logic                   sat;
	logic [DIFF_W:0]        shifted;
	logic                   ge;
	logic [DIFF_W:0]        diff;
	logic                   ovf;

	// quotient bits above bit 31 are nonzero exactly when mag >> 16 >= den
	assign top     = DIFF_W'(req.mag[DIFF_W-1:FRAC_W]);
	assign zero    = (req.mag == '0);
	assign sat     = (top >= req.den);
	assign shifted = {rem_q, num_q[COORD_W-1]};
	assign ge      = (shifted >= {1'b0, den_q});
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= !(zero || sat);
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q  <= req.den;
			neg_q  <= req.neg;
			zero_q <= zero;
			sat_q  <= sat;
			rem_q  <= top;
			num_q  <= {req.mag[FRAC_W-1:0], FRAC_W'(0)};
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIFF_W-1:0] : shifted[DIFF_W-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[COORD_W-2:0], ge};
		end
	end

	// magnitude past the signed range saturates
	assign ovf = neg_q ? (quo_q[COORD_W-1] && (|quo_q[COORD_W-2:0])) : quo_q[COORD_W-1];

	always_comb begin
		rsp.busy = busy_q;
		if (zero_q) begin
			rsp.slope = '0;
		end else if (sat_q || ovf) begin
			rsp.slope = neg_q ? SLOPE_MIN : SLOPE_MAX;
		end else begin
			rsp.slope = neg_q ? -$signed(quo_q) : $signed(quo_q);
		end
	end

endmodule

// ===== sv/grbw_datapath.sv =====
// Axis setup, intercept arithmetic and block walk driven by the control word.
module grbw_datapath import grbw_pkg::*; #(
	parameter int MAX_STEPS        = MAX_STEPS_DEF,
	parameter int BLOCK_SHIFT      = BLOCK_SHIFT_DEF,
	parameter int BLOCK_COORD_BITS = BLOCK_COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	grbw_ray_if.sink         ray,
	grbw_visit_if.source     visit,
	input  ctrl_t            ctrl,
	output stat_t            stat
);

	localparam int BW    = BLOCK_COORD_BITS;
	localparam int CNT_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [BW-1:0]             bx_q, by_q, ebx_q, eby_q;
	logic [BW-1:0]             dirx_q, diry_q;
	logic [PART_W-1:0]         partial_q;
	logic                      still_q;
	logic signed [COORD_W-1:0] slope_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [COORD_W-1:0]        icx_q, icy_q, stepx_q, stepy_q;
	logic [CNT_W-1:0]          n_q;

	logic                      ovalid_q;
	logic [VISIT_W-1:0]        vx_q, vy_q;
	logic                      last_q, reached_q;

	logic signed [COORD_W-1:0] s_this, e_this, s_other, e_other;
	logic [COORD_W-1:0]        s_this_u;
	logic [BW-1:0]             b0, b1;
	logic signed [DIFF_W-1:0]  d_this, d_other;
	logic [DIFF_W-1:0]         d_this_abs, d_other_abs;
	logic [FRAC_W-1:0]         frac;
	logic                      go_up, go_down;
	logic [COORD_W-1:0]        icpt_sum;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	logic                      accept;
	logic                      at_end, final_blk, fire;
	logic                      match_y, match_x;

	// operand selection for the axis in setup
	always_comb begin
		if (ctrl.axis == AXIS_X) begin
			s_this  = sx_q;
			e_this  = ex_q;
			s_other = sy_q;
			e_other = ey_q;
			b0      = bx_q;
			b1      = ebx_q;
		end else begin
			s_this  = sy_q;
			e_this  = ey_q;
			s_other = sx_q;
			e_other = ex_q;
			b0      = by_q;
			b1      = eby_q;
		end
	end

	assign d_this      = {e_this[COORD_W-1], e_this} - {s_this[COORD_W-1], s_this};
	assign d_other     = {e_other[COORD_W-1], e_other} - {s_other[COORD_W-1], s_other};
	assign d_this_abs  = d_this[DIFF_W-1] ? DIFF_W'(-d_this) : DIFF_W'(d_this);
	assign d_other_abs = d_other[DIFF_W-1] ? DIFF_W'(-d_other) : DIFF_W'(d_other);
	assign s_this_u    = s_this;
	assign frac        = FRAC_W'(s_this_u >> BLOCK_SHIFT);
	assign go_up       = (b1 > b0);
	assign go_down     = (b1 < b0);

	assign div_req.start = (ctrl.op == OP_SETUP);
	assign div_req.mag   = d_other_abs;
	assign div_req.den   = d_this_abs;
	assign div_req.neg   = d_other[DIFF_W-1];

	grbw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// floor(partial * slope / 65536) plus the block-unit start, wrapping at 32 bits
	assign icpt_sum = COORD_W'(s_other >>> BLOCK_SHIFT) + COORD_W'(prod_q[FRAC_W +: COORD_W]);

	assign accept    = ray.valid && ray.ready;
	assign ray.ready = (ctrl.op == OP_LOAD);

	assign at_end    = (bx_q == ebx_q) && (by_q == eby_q);
	assign final_blk = at_end || (n_q == CNT_W'(MAX_STEPS - 1));
	assign fire      = (ctrl.op == OP_EMIT) && (!ovalid_q || visit.ready);
	assign match_y   = !icy_q[COORD_W-1] && (icy_q[COORD_W-1:FRAC_W] == FRAC_W'(by_q));
	assign match_x   = !icx_q[COORD_W-1] && (icx_q[COORD_W-1:FRAC_W] == FRAC_W'(bx_q));

	assign stat.in_valid  = ray.valid;
	assign stat.div_busy  = div_rsp.busy;
	assign stat.emit_last = fire && final_blk;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (accept) begin
					sx_q  <= ray.start_x;
					sy_q  <= ray.start_y;
					ex_q  <= ray.end_x;
					ey_q  <= ray.end_y;
					bx_q  <= BW'(ray.start_block_x);
					by_q  <= BW'(ray.start_block_y);
					ebx_q <= BW'(ray.end_block_x);
					eby_q <= BW'(ray.end_block_y);
					n_q   <= '0;
				end
			end
			OP_SETUP: begin
				if (go_up) begin
					partial_q <= FRAC_ONE - PART_W'(frac);
				end else if (go_down) begin
					partial_q <= PART_W'(frac);
				end else begin
					partial_q <= FRAC_ONE;
				end
				still_q <= !(go_up || go_down);
				if (ctrl.axis == AXIS_X) begin
					dirx_q <= go_up ? BW'(1) : (go_down ? {BW{1'b1}} : '0);
				end else begin
					diry_q <= go_up ? BW'(1) : (go_down ? {BW{1'b1}} : '0);
				end
			end
			OP_SLOPE: begin
				slope_q <= still_q ? STILL_SLOPE : div_rsp.slope;
			end
			OP_MUL: begin
				prod_q <= $signed({1'b0, partial_q}) * slope_q;
			end
			OP_ICPT: begin
				if (ctrl.axis == AXIS_X) begin
					icy_q   <= icpt_sum;
					stepy_q <= slope_q;
				end else begin
					icx_q   <= icpt_sum;
					stepx_q <= slope_q;
				end
			end
			OP_EMIT: begin
				if (fire) begin
					vx_q      <= VISIT_W'(bx_q);
					vy_q      <= VISIT_W'(by_q);
					last_q    <= final_blk;
					reached_q <= final_blk && at_end;
					n_q       <= n_q + 1'b1;
					if (match_y) begin
						icy_q <= icy_q + stepy_q;
						bx_q  <= bx_q + dirx_q;
					end else if (match_x) begin
						icx_q <= icx_q + stepx_q;
						by_q  <= by_q + diry_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (fire) begin
			ovalid_q <= 1'b1;
		end else if (visit.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign visit.valid       = ovalid_q;
	assign visit.visit_x     = vx_q;
	assign visit.visit_y     = vy_q;
	assign visit.last_visit  = last_q;
	assign visit.reached_end = reached_q;

endmodule

// ===== sv/grid_ray_block_walker.sv =====
// Top level of the grid ray block walker: microcode sequencer plus datapath.
//
//  channel  dir  handshake        payload
//  ray      in   valid / ready    start_x, start_y, end_x, end_y (s32),
//                                 start_block_x/y, end_block_x/y (u8)
//  visit    out  valid / ready    visit_x, visit_y (u8), last_visit, reached_end
//
// One ray at a time: a load step, then per axis a setup step, the divider wait (no
// divide runs when the quotient is zero or saturates), then slope, multiply and
// intercept steps. Blocks then leave one per cycle, up to MAX_STEPS; a stalled
// visit channel holds the walk in place. The next ray is taken once the final
// block is in the output register. Reset clears the step counter and the output valid.
module grid_ray_block_walker import grbw_pkg::*; #(
	parameter int MAX_STEPS        = MAX_STEPS_DEF,
	parameter int BLOCK_SHIFT      = BLOCK_SHIFT_DEF,
	parameter int BLOCK_COORD_BITS = BLOCK_COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	grbw_ray_if.sink     ray,
	grbw_visit_if.source visit
);

	ctrl_t ctrl;
	stat_t stat;

	grbw_ucode u_ucode (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	grbw_datapath #(
		.MAX_STEPS        (MAX_STEPS),
		.BLOCK_SHIFT      (BLOCK_SHIFT),
		.BLOCK_COORD_BITS (BLOCK_COORD_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ray    (ray),
		.visit  (visit),
		.ctrl   (ctrl),
		.stat   (stat)
	);

endmodule

// ===== test/grbw_visit_checker.sv =====
// Checker for the block walker: watches both channels, predicts visits, compares.
module grbw_visit_checker import grbw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	grbw_ray_if         ray,
	grbw_visit_if       visit,
	output int unsigned mismatches,
	output int unsigned pending
);

	localparam logic [VISIT_W-1:0] DIR_FWD  = VISIT_W'(1);
	localparam logic [VISIT_W-1:0] DIR_BACK = '1;
	localparam logic [VISIT_W-1:0] DIR_HOLD = '0;

	typedef struct packed {
		logic [VISIT_W-1:0] x;
		logic [VISIT_W-1:0] y;
		logic               last;
		logic               reached;
	} visit_t;

	visit_t      due_visits[$];
	int unsigned fail_tally = 0;

	// 16.16 quotient, truncated toward zero and saturated to 32 bits
	function automatic longint ray_slope(input longint num, input longint den);
		longint q;
		if (den == 0) begin
			if (num > 0)
				return longint'(SLOPE_MAX);
			if (num < 0)
				return longint'(SLOPE_MIN);
			return 0;
		end
		q = (num * 65536) / den;
		if (q > longint'(SLOPE_MAX))
			q = longint'(SLOPE_MAX);
		if (q < longint'(SLOPE_MIN))
			q = longint'(SLOPE_MIN);
		return q;
	endfunction

	// Motion along this axis sets its step and the other axis' slope and intercept.
	function automatic void setup_axis(input longint s_this, e_this, s_other, e_other,
			input logic [VISIT_W-1:0] b0, b1, output logic [VISIT_W-1:0] dir,
			output logic [COORD_W-1:0] slope_out, output logic [COORD_W-1:0] icpt);
		longint span;
		longint rise;
		longint frac;
		longint part;
		longint slope;
		span = e_this - s_this;
		rise = e_other - s_other;
		if (span < 0)
			span = -span;
		frac = longint'(s_this[BLOCK_SHIFT_DEF +: FRAC_W]);
		if (b1 > b0) begin
			dir   = DIR_FWD;
			part  = longint'(FRAC_ONE) - frac;
			slope = ray_slope(rise, span);
		end else if (b1 < b0) begin
			dir   = DIR_BACK;
			part  = frac;
			slope = ray_slope(rise, span);
		end else begin
			dir   = DIR_HOLD;
			part  = longint'(FRAC_ONE);
			slope = longint'(STILL_SLOPE);
		end
		slope_out = slope[COORD_W-1:0];
		icpt = COORD_W'((s_other >>> BLOCK_SHIFT_DEF) + ((part * slope) >>> FRAC_W));
	endfunction

	function automatic logic lands_on(input logic [COORD_W-1:0] icpt,
			input logic [VISIT_W-1:0] blk);
		return !icpt[COORD_W-1] && (icpt[COORD_W-1:FRAC_W] == FRAC_W'(blk));
	endfunction

	function automatic void trace_ray_blocks(input longint sx, sy, ex, ey,
			input logic [VISIT_W-1:0] bx0, by0, ebx, eby);
		logic [VISIT_W-1:0] bx;
		logic [VISIT_W-1:0] by;
		logic [VISIT_W-1:0] dirx;
		logic [VISIT_W-1:0] diry;
		logic [COORD_W-1:0] stepx;
		logic [COORD_W-1:0] stepy;
		logic [COORD_W-1:0] icx;
		logic [COORD_W-1:0] icy;
		logic               at_end;
		logic               fin;
		visit_t             v;
		bx = bx0;
		by = by0;
		setup_axis(sx, ex, sy, ey, bx, ebx, dirx, stepy, icy);
		setup_axis(sy, ey, sx, ex, by, eby, diry, stepx, icx);
		for (int n = 0; n < MAX_STEPS_DEF; n++) begin
			at_end    = (bx == ebx) && (by == eby);
			fin       = at_end || (n == MAX_STEPS_DEF - 1);
			v.x       = bx;
			v.y       = by;
			v.last    = fin;
			v.reached = fin && at_end;
			due_visits.push_back(v);
			if (fin)
				break;
			// y intercept crossing the current row moves x; otherwise try the other axis
			if (lands_on(icy, by)) begin
				icy += stepy;
				bx  += dirx;
			end else if (lands_on(icx, bx)) begin
				icx += stepx;
				by  += diry;
			end
		end
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_tally++;
		end
	endfunction

	always @(posedge clk) begin
		visit_t want;
		if (arst_n) begin
			if (ray.valid && ray.ready)
				trace_ray_blocks(longint'(ray.start_x), longint'(ray.start_y),
					longint'(ray.end_x), longint'(ray.end_y),
					ray.start_block_x, ray.start_block_y,
					ray.end_block_x, ray.end_block_y);
			if (visit.valid && visit.ready) begin
				if (due_visits.size() == 0) begin
					$error("visit transfer with none expected: x %0d y %0d",
						visit.visit_x, visit.visit_y);
					fail_tally++;
				end else begin
					want = due_visits.pop_front();
					compare_field("visit_x", want.x, visit.visit_x);
					compare_field("visit_y", want.y, visit.visit_y);
					compare_field("last_visit", want.last, visit.last_visit);
					compare_field("reached_end", want.reached, visit.reached_end);
				end
			end
			mismatches <= fail_tally;
			pending    <= due_visits.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the grid ray block walker: clock, reset, stimulus and verdict.
module tb;
	import grbw_pkg::*;

	localparam int BLK        = 1 << (FRAC_W + BLOCK_SHIFT_DEF);
	localparam int HALF       = BLK / 2;
	localparam int RAND_RAYS  = 300;
	localparam int CALM_FROM  = 260;
	localparam int SQUEEZE_AT = 90;
	localparam int LIMIT      = 1_000_000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        calm    = 1'b0;
	logic        squeeze = 1'b0;
	int unsigned mismatches;
	int unsigned pending;
	int          cycle_count = 0;

	grbw_ray_if   ray_ch ();
	grbw_visit_if visit_ch ();

	grid_ray_block_walker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.ray    (ray_ch),
		.visit  (visit_ch)
	);

	grbw_visit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.ray        (ray_ch),
		.visit      (visit_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("grid_ray_block_walker regression: fail");
			$finish;
		end
	end

	function automatic logic signed [COORD_W-1:0] fold_to_grid(input longint v);
		if (v > longint'(SLOPE_MAX))
			return SLOPE_MAX;
		if (v < 0)
			return '0;
		return COORD_W'(v);
	endfunction

	// Returns right after the accepting edge; valid stays high unless a gap follows.
	task automatic offer_ray(input logic signed [COORD_W-1:0] sx, sy, ex, ey,
			input logic [BLK_IN_W-1:0] bx, by, ebx, eby);
		if (!calm && $urandom_range(0, 3) == 0) begin
			ray_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		ray_ch.valid         <= 1'b1;
		ray_ch.start_x       <= sx;
		ray_ch.start_y       <= sy;
		ray_ch.end_x         <= ex;
		ray_ch.end_y         <= ey;
		ray_ch.start_block_x <= bx;
		ray_ch.start_block_y <= by;
		ray_ch.end_block_x   <= ebx;
		ray_ch.end_block_y   <= eby;
		do @(posedge clk); while (!ray_ch.ready);
	endtask

	// Ray whose block fields agree with its coordinates
	task automatic offer_path(input logic signed [COORD_W-1:0] sx, sy, ex, ey);
		offer_ray(sx, sy, ex, ey, sx[30:23], sy[30:23], ex[30:23], ey[30:23]);
	endtask

	// Visit side: random stall bursts, one long hold-off, none near the end.
	initial begin
		int  hold_left;
		logic squeezed;
		hold_left = 0;
		squeezed  = 1'b0;
		visit_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				visit_ch.ready <= 1'b0;
				hold_left--;
			end else if (squeeze && !squeezed) begin
				squeezed  = 1'b1;
				hold_left = 400;
				visit_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 9);
				visit_ch.ready <= 1'b0;
			end else begin
				visit_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic signed [COORD_W-1:0] sx, sy, ex, ey;
		logic [BLK_IN_W-1:0]       bx, by, ebx, eby;
		longint                    dx, dy;
		int                        reach;
		int                        pick;
		ray_ch.valid         <= 1'b0;
		ray_ch.start_x       <= '0;
		ray_ch.start_y       <= '0;
		ray_ch.end_x         <= '0;
		ray_ch.end_y         <= '0;
		ray_ch.start_block_x <= '0;
		ray_ch.start_block_y <= '0;
		ray_ch.end_block_x   <= '0;
		ray_ch.end_block_y   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rays
		offer_path(5*BLK + 100, 5*BLK + 100, 5*BLK + 9000, 5*BLK + 77);
		offer_path(10*BLK + HALF, 10*BLK + HALF, 14*BLK + HALF, 10*BLK + HALF + 4096);
		offer_path(14*BLK + HALF, 10*BLK + HALF, 10*BLK + HALF, 10*BLK + HALF);
		offer_path(30*BLK + 1000, 30*BLK + 5, 30*BLK + 1000, 37*BLK + 5);
		offer_path(30*BLK + 1000, 37*BLK + 5, 30*BLK + 1000, 30*BLK + 5);
		offer_path(20*BLK + HALF, 20*BLK + HALF, 26*BLK + HALF, 23*BLK + BLK/4);
		offer_path(26*BLK + HALF, 23*BLK + BLK/4, 20*BLK + HALF, 20*BLK + HALF);
		offer_path(3*BLK + HALF, 3*BLK + HALF, 7*BLK + HALF, 7*BLK + HALF);
		offer_path(9*BLK + HALF, 2*BLK + HALF, 4*BLK + HALF, 8*BLK + 100);
		// blocks differ while the coordinates on that axis do not move
		offer_ray(12*BLK, 12*BLK, 12*BLK, 15*BLK, 8'd10, 8'd12, 8'd14, 8'd15);
		offer_ray(12*BLK, 15*BLK, 12*BLK, 12*BLK, 8'd10, 8'd15, 8'd14, 8'd12);
		offer_ray(12*BLK, 12*BLK, 12*BLK, 12*BLK, 8'd10, 8'd12, 8'd14, 8'd12);
		offer_ray(12*BLK, 12*BLK, 15*BLK, 12*BLK, 8'd12, 8'd10, 8'd15, 8'd13);
		// field extremes
		offer_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
			8'hFF, 8'hFF, 8'h00, 8'h00);
		offer_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			8'h00, 8'h00, 8'hFF, 8'hFF);
		offer_ray(0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		offer_path(0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		offer_path(32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF);
		offer_path(0, 0, 200*BLK, 150*BLK);
		// column index wraps past the grid edge
		sx = 255*BLK + HALF;
		ex = sx + 3*BLK;
		offer_ray(sx, 5*BLK + HALF, ex, 6*BLK + HALF, 8'd255, 8'd5, 8'd2, 8'd6);
		// start block disagrees with the coordinates: no intercept lines up
		offer_ray(40*BLK + 7, 40*BLK + 7, 44*BLK, 41*BLK, 8'd3, 8'd200, 8'd6, 8'd201);

		for (int i = 0; i < RAND_RAYS; i++) begin
			calm = (i >= CALM_FROM);
			if (i == SQUEEZE_AT)
				squeeze = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				offer_ray($urandom, $urandom, $urandom, $urandom, 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				reach = ($urandom_range(0, 9) < 7) ? 8 : ($urandom_range(0, 1) ? 40 : 120);
				sx = $urandom_range(0, 32'h7FFF_FFFF);
				sy = $urandom_range(0, 32'h7FFF_FFFF);
				dx = longint'($urandom_range(0, 2*reach*BLK)) - longint'(reach*BLK);
				dy = longint'($urandom_range(0, 2*reach*BLK)) - longint'(reach*BLK);
				case ($urandom_range(0, 6))
					0: dx = 0;
					1: dy = 0;
					default: ;
				endcase
				ex  = fold_to_grid(longint'(sx) + dx);
				ey  = fold_to_grid(longint'(sy) + dy);
				bx  = sx[30:23];
				by  = sy[30:23];
				ebx = ex[30:23];
				eby = ey[30:23];
				if (pick < 22) begin
					case ($urandom_range(0, 3))
						0: bx  = 8'($urandom);
						1: by  = 8'($urandom);
						2: ebx = 8'($urandom);
						default: eby = 8'($urandom);
					endcase
				end
				offer_ray(sx, sy, ex, ey, bx, by, ebx, eby);
			end
		end
		ray_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("grid_ray_block_walker regression: pass");
		else
			$display("grid_ray_block_walker regression: fail");
		$finish;
	end

endmodule
